// File: hw/rtl/urhr_pkg.sv
// Shared types and constants for the undo/redo history rings.
// Holds the ring depth, the edit-descriptor word layout and the ring pointer helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package urhr_pkg;

  // Ring depth and derived widths
  localparam int HIST_DEPTH = 64;
  localparam int ADDR_W     = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int FILL_W     = $clog2(HIST_DEPTH + 1);
  localparam int OFS_W      = 16;

  localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(HIST_DEPTH - 1);
  localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(HIST_DEPTH);

  // Command codes
  typedef enum logic [1:0] {
    CMD_RECORD = 2'd0,
    CMD_UNDO   = 2'd1,
    CMD_REDO   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  // One edit descriptor as stored in a ring
  typedef struct packed {
    logic [OFS_W-1:0] pos;
    logic [OFS_W-1:0] removed;
    logic [OFS_W-1:0] inserted;
    logic [OFS_W-1:0] caret_prior;
    logic [OFS_W-1:0] mark_prior;
    logic             select_prior;
    logic [OFS_W-1:0] caret_later;
    logic [OFS_W-1:0] mark_later;
    logic             select_later;
  } hist_entry_t;

  // Advance a ring pointer with wrap
  function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
    ptr_inc = (p == LAST_SLOT) ? '0 : p + ADDR_W'(1);
  endfunction

  // Step a ring pointer back with wrap
  function automatic logic [ADDR_W-1:0] ptr_dec(input logic [ADDR_W-1:0] p);
    ptr_dec = (p == '0) ? LAST_SLOT : p - ADDR_W'(1);
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/undo_redo_history_rings_unit.sv
// Undo/redo history rings: two bounded rings of edit descriptors in synchronous memories.
// Depends on urhr_pkg for the descriptor word, command codes and pointer helpers.
//
//   port group   dir   handshake              word
//   in_*         in    in_valid / in_ready    command plus one edit descriptor
//   out_*        out   out_valid / out_ready  done flag, returned descriptor, ring status
//
// For each word, the accept edge launches the read of the newest entry of both ring
// memories; in the execute state that follows, a ring is written where the command needs
// it and the result word is loaded. A new word is taken once the block is back in idle,
// as long as the result register is empty or is being drained in that cycle.
// rst_n (synchronous) empties both rings at once through their fill counts; there is no
// clearing pass. A stalled out_ready holds the result and blocks further input.
`timescale 1ns / 1ps
`default_nettype none

module undo_redo_history_rings_unit (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire  [1:0]               in_command,
  input  wire  [urhr_pkg::OFS_W-1:0] in_span_pos,
  input  wire  [urhr_pkg::OFS_W-1:0] in_removed_len,
  input  wire  [urhr_pkg::OFS_W-1:0] in_inserted_len,
  input  wire  [urhr_pkg::OFS_W-1:0] in_caret_prior,
  input  wire  [urhr_pkg::OFS_W-1:0] in_mark_prior,
  input  wire                      in_select_prior,
  input  wire  [urhr_pkg::OFS_W-1:0] in_caret_later,
  input  wire  [urhr_pkg::OFS_W-1:0] in_mark_later,
  input  wire                      in_select_later,
  output logic                     out_valid,
  input  wire                      out_ready,
  output logic                     out_done_res,
  output logic [urhr_pkg::OFS_W-1:0] out_pos,
  output logic [urhr_pkg::OFS_W-1:0] out_removed,
  output logic [urhr_pkg::OFS_W-1:0] out_inserted,
  output logic [urhr_pkg::OFS_W-1:0] out_caret_prior,
  output logic [urhr_pkg::OFS_W-1:0] out_mark_prior,
  output logic                     out_select_prior,
  output logic [urhr_pkg::OFS_W-1:0] out_caret_later,
  output logic [urhr_pkg::OFS_W-1:0] out_mark_later,
  output logic                     out_select_later,
  output logic                     out_undo_available,
  output logic                     out_redo_available
);

  import urhr_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // Ring memories
  hist_entry_t undo_mem [HIST_DEPTH];
  hist_entry_t redo_mem [HIST_DEPTH];

  state_t            state_r, state_nxt;
  cmd_t              cmd_r;
  hist_entry_t       in_entry_r;
  hist_entry_t       undo_rd_r, redo_rd_r;

  logic [ADDR_W-1:0] undo_top_r, undo_top_nxt;
  logic [ADDR_W-1:0] redo_top_r, redo_top_nxt;
  logic [FILL_W-1:0] undo_fill_r, undo_fill_nxt;
  logic [FILL_W-1:0] redo_fill_r, redo_fill_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              done_r, done_nxt;
  hist_entry_t       res_r, res_nxt;
  logic              undo_av_r, undo_av_nxt;
  logic              redo_av_r, redo_av_nxt;

  logic              undo_we, redo_we;
  hist_entry_t       undo_wdata, redo_wdata;
  logic              accept;
  hist_entry_t       in_entry;

  assign accept = in_valid && in_ready;

  // Gather the incoming descriptor
  always_comb begin
    in_entry.pos          = in_span_pos;
    in_entry.removed      = in_removed_len;
    in_entry.inserted     = in_inserted_len;
    in_entry.caret_prior  = in_caret_prior;
    in_entry.mark_prior   = in_mark_prior;
    in_entry.select_prior = in_select_prior;
    in_entry.caret_later  = in_caret_later;
    in_entry.mark_later   = in_mark_later;
    in_entry.select_later = in_select_later;
  end

  // Take a word only when idle and the result register is free or draining
  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);

  // Capture the command and descriptor on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r      <= cmd_t'(in_command);
      in_entry_r <= in_entry;
    end
  end

  // Read the newest entry of each ring; pointers are stable during the read
  always_ff @(posedge clk) begin
    undo_rd_r <= undo_mem[ptr_dec(undo_top_r)];
    redo_rd_r <= redo_mem[ptr_dec(redo_top_r)];
  end

  // Write back into the rings
  always_ff @(posedge clk) begin
    if (undo_we) begin
      undo_mem[undo_top_r] <= undo_wdata;
    end
    if (redo_we) begin
      redo_mem[redo_top_r] <= redo_wdata;
    end
  end

  // Execute the command in the cycle after accept
  always_comb begin
    state_nxt     = state_r;
    undo_top_nxt  = undo_top_r;
    redo_top_nxt  = redo_top_r;
    undo_fill_nxt = undo_fill_r;
    redo_fill_nxt = redo_fill_r;
    out_valid_nxt = out_valid_r && !out_ready;
    done_nxt      = done_r;
    res_nxt       = res_r;
    undo_av_nxt   = undo_av_r;
    redo_av_nxt   = redo_av_r;
    undo_we       = 1'b0;
    redo_we       = 1'b0;
    undo_wdata    = in_entry_r;
    redo_wdata    = undo_rd_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        done_nxt      = 1'b0;
        res_nxt       = '0;
        case (cmd_r)
          CMD_RECORD: begin
            if ((in_entry_r.removed != '0) || (in_entry_r.inserted != '0)) begin
              undo_we       = 1'b1;
              undo_wdata    = in_entry_r;
              undo_top_nxt  = ptr_inc(undo_top_r);
              if (undo_fill_r != FULL_FILL) begin
                undo_fill_nxt = undo_fill_r + FILL_W'(1);
              end
              redo_top_nxt  = '0;
              redo_fill_nxt = '0;
              done_nxt      = 1'b1;
            end
          end
          CMD_UNDO: begin
            if (undo_fill_r != '0) begin
              undo_top_nxt  = ptr_dec(undo_top_r);
              undo_fill_nxt = undo_fill_r - FILL_W'(1);
              redo_we       = 1'b1;
              redo_wdata    = undo_rd_r;
              redo_top_nxt  = ptr_inc(redo_top_r);
              if (redo_fill_r != FULL_FILL) begin
                redo_fill_nxt = redo_fill_r + FILL_W'(1);
              end
              done_nxt      = 1'b1;
              res_nxt       = undo_rd_r;
            end
          end
          CMD_REDO: begin
            if (redo_fill_r != '0) begin
              redo_top_nxt  = ptr_dec(redo_top_r);
              redo_fill_nxt = redo_fill_r - FILL_W'(1);
              undo_we       = 1'b1;
              undo_wdata    = redo_rd_r;
              undo_top_nxt  = ptr_inc(undo_top_r);
              if (undo_fill_r != FULL_FILL) begin
                undo_fill_nxt = undo_fill_r + FILL_W'(1);
              end
              done_nxt      = 1'b1;
              res_nxt       = redo_rd_r;
            end
          end
          CMD_CLEAR: begin
            undo_top_nxt  = '0;
            undo_fill_nxt = '0;
            redo_top_nxt  = '0;
            redo_fill_nxt = '0;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
        undo_av_nxt = (undo_fill_nxt != '0);
        redo_av_nxt = (redo_fill_nxt != '0);
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state, ring pointers and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      undo_top_r  <= '0;
      redo_top_r  <= '0;
      undo_fill_r <= '0;
      redo_fill_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      undo_top_r  <= undo_top_nxt;
      redo_top_r  <= redo_top_nxt;
      undo_fill_r <= undo_fill_nxt;
      redo_fill_r <= redo_fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
    done_r    <= done_nxt;
    res_r     <= res_nxt;
    undo_av_r <= undo_av_nxt;
    redo_av_r <= redo_av_nxt;
  end

  // Drive the result word
  assign out_valid          = out_valid_r;
  assign out_done_res       = done_r;
  assign out_pos            = res_r.pos;
  assign out_removed        = res_r.removed;
  assign out_inserted       = res_r.inserted;
  assign out_caret_prior    = res_r.caret_prior;
  assign out_mark_prior     = res_r.mark_prior;
  assign out_select_prior   = res_r.select_prior;
  assign out_caret_later    = res_r.caret_later;
  assign out_mark_later     = res_r.mark_later;
  assign out_select_later   = res_r.select_later;
  assign out_undo_available = undo_av_r;
  assign out_redo_available = redo_av_r;

  // Fill counts never pass the ring depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (undo_fill_r <= FULL_FILL) && (redo_fill_r <= FULL_FILL))
    else $error("ring fill count beyond depth");

  // The execute state is entered only in the cycle after a word was accepted
  a_result_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) |-> $past(accept))
    else $error("execute cycle without an accepted word");

  // No word is taken while one is being executed
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) |-> !in_ready)
    else $error("input accepted during execute");

  // Status flags in a pending result agree with the ring fill counts
  a_status_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (state_r == ST_IDLE)) |->
      ((undo_av_r == (undo_fill_r != '0)) && (redo_av_r == (redo_fill_r != '0))))
    else $error("result status disagrees with ring fill");

endmodule

`default_nettype wire

// File: sim/history_rings_checker.sv
// Scoreboard for the undo/redo history rings: watches both channels, keeps its own copy
// of the two rings and compares every result word with the expected one.
// Depends on urhr_pkg for the command codes, ring depth and descriptor layout.
`timescale 1ns / 1ps

module history_rings_checker
  import urhr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  cmd_t        in_cmd,
  input  hist_entry_t in_word,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_done_res,
  input  hist_entry_t out_word,
  input  logic        out_undo_available,
  input  logic        out_redo_available,
  output int          fail_count,
  output int          pending
);

  localparam int UNDO_RING = 0;
  localparam int REDO_RING = 1;

  typedef struct packed {
    logic        done;
    hist_entry_t entry;
    logic        undo_av;
    logic        redo_av;
  } outcome_t;

  // Shadow copy of both rings
  hist_entry_t ring_slot [2][HIST_DEPTH];
  int          ring_top  [2];
  int          ring_fill [2];
  outcome_t    outcome_q [$];
  int          mismatches = 0;

  assign fail_count = mismatches;

  function automatic void shadow_wipe(input int r);
    ring_top[r]  = 0;
    ring_fill[r] = 0;
  endfunction

  // Push onto a ring, overwriting the oldest entry once it is full
  function automatic void shadow_store(input int r, input hist_entry_t e);
    ring_slot[r][ring_top[r]] = e;
    ring_top[r] = (ring_top[r] + 1) % HIST_DEPTH;
    if (ring_fill[r] < HIST_DEPTH) ring_fill[r]++;
  endfunction

  function automatic bit shadow_fetch(input int r, output hist_entry_t e);
    e = '0;
    if (ring_fill[r] == 0) return 1'b0;
    ring_top[r] = (ring_top[r] + HIST_DEPTH - 1) % HIST_DEPTH;
    ring_fill[r]--;
    e = ring_slot[r][ring_top[r]];
    return 1'b1;
  endfunction

  // Apply one command word to the shadow rings and form the result it gives
  function automatic outcome_t predict_history(input cmd_t c, input hist_entry_t w);
    outcome_t    o;
    hist_entry_t e;
    o = '0;
    case (c)
      CMD_RECORD: begin
        // a record with both lengths zero changes nothing
        if (w.removed != '0 || w.inserted != '0) begin
          shadow_store(UNDO_RING, w);
          shadow_wipe(REDO_RING);
          o.done = 1'b1;
        end
      end
      CMD_UNDO: begin
        if (shadow_fetch(UNDO_RING, e)) begin
          shadow_store(REDO_RING, e);
          o.done  = 1'b1;
          o.entry = e;
        end
      end
      CMD_REDO: begin
        if (shadow_fetch(REDO_RING, e)) begin
          shadow_store(UNDO_RING, e);
          o.done  = 1'b1;
          o.entry = e;
        end
      end
      default: begin
        shadow_wipe(UNDO_RING);
        shadow_wipe(REDO_RING);
      end
    endcase
    o.undo_av = (ring_fill[UNDO_RING] != 0);
    o.redo_av = (ring_fill[REDO_RING] != 0);
    return o;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $error("%s expected %h actual %h", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare drained words first, then predict the word taken at this edge
  always @(posedge clk) begin
    outcome_t want;
    if (!rst_n) begin
      shadow_wipe(UNDO_RING);
      shadow_wipe(REDO_RING);
      outcome_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (outcome_q.size() == 0) begin
          $error("result word with no expectation pending");
          mismatches++;
        end else begin
          want = outcome_q.pop_front();
          check_field("done_res", 16'(want.done), 16'(out_done_res));
          check_field("out_pos", want.entry.pos, out_word.pos);
          check_field("out_removed", want.entry.removed, out_word.removed);
          check_field("out_inserted", want.entry.inserted, out_word.inserted);
          check_field("out_caret_prior", want.entry.caret_prior, out_word.caret_prior);
          check_field("out_mark_prior", want.entry.mark_prior, out_word.mark_prior);
          check_field("out_select_prior", 16'(want.entry.select_prior),
                      16'(out_word.select_prior));
          check_field("out_caret_later", want.entry.caret_later, out_word.caret_later);
          check_field("out_mark_later", want.entry.mark_later, out_word.mark_later);
          check_field("out_select_later", 16'(want.entry.select_later),
                      16'(out_word.select_later));
          check_field("undo_available", 16'(want.undo_av), 16'(out_undo_available));
          check_field("redo_available", 16'(want.redo_av), 16'(out_redo_available));
        end
      end
      if (in_valid && in_ready) outcome_q.push_back(predict_history(in_cmd, in_word));
    end
    // Report how many words are still owed by the block
    pending = outcome_q.size();
  end

endmodule

// File: sim/tb_top.sv
// Testbench top for the undo/redo history rings: clock, reset, command stimulus with
// random idling on both sides, and the verdict. Depends on urhr_pkg, the block and
// history_rings_checker.
`timescale 1ns / 1ps

module tb_top;
  import urhr_pkg::*;

  localparam int RANDOM_WORDS = 1650;
  localparam int CYCLE_LIMIT  = 200000;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        out_ready = 1'b0;
  logic        calm      = 1'b0;
  cmd_t        in_cmd    = CMD_RECORD;
  hist_entry_t in_word   = '0;
  logic        in_ready;
  logic        out_valid;
  logic        out_done_res;
  logic [OFS_W-1:0] out_pos, out_removed, out_inserted;
  logic [OFS_W-1:0] out_caret_prior, out_mark_prior, out_caret_later, out_mark_later;
  logic        out_select_prior, out_select_later;
  logic        out_undo_available, out_redo_available;
  hist_entry_t out_word;
  int          fail_count;
  int          pending;
  int          cycles = 0;

  assign out_word = {out_pos, out_removed, out_inserted, out_caret_prior, out_mark_prior,
                     out_select_prior, out_caret_later, out_mark_later, out_select_later};

  always #5 clk = ~clk;

  undo_redo_history_rings_unit i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_cmd),
    .in_span_pos        (in_word.pos),
    .in_removed_len     (in_word.removed),
    .in_inserted_len    (in_word.inserted),
    .in_caret_prior     (in_word.caret_prior),
    .in_mark_prior      (in_word.mark_prior),
    .in_select_prior    (in_word.select_prior),
    .in_caret_later     (in_word.caret_later),
    .in_mark_later      (in_word.mark_later),
    .in_select_later    (in_word.select_later),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_done_res       (out_done_res),
    .out_pos            (out_pos),
    .out_removed        (out_removed),
    .out_inserted       (out_inserted),
    .out_caret_prior    (out_caret_prior),
    .out_mark_prior     (out_mark_prior),
    .out_select_prior   (out_select_prior),
    .out_caret_later    (out_caret_later),
    .out_mark_later     (out_mark_later),
    .out_select_later   (out_select_later),
    .out_undo_available (out_undo_available),
    .out_redo_available (out_redo_available)
  );

  history_rings_checker i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_cmd             (in_cmd),
    .in_word            (in_word),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_done_res       (out_done_res),
    .out_word           (out_word),
    .out_undo_available (out_undo_available),
    .out_redo_available (out_redo_available),
    .fail_count         (fail_count),
    .pending            (pending)
  );

  // Stall the result side about a third of the time, never during the calm stretch
  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 35);
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Offsets lean towards the extremes now and then
  function automatic logic [OFS_W-1:0] rand_ofs();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return '1;
      default: return OFS_W'($urandom);
    endcase
  endfunction

  function automatic logic [OFS_W-1:0] rand_len();
    return ($urandom_range(0, 4) == 0) ? '0 : rand_ofs();
  endfunction

  function automatic hist_entry_t random_entry();
    hist_entry_t e;
    e.pos          = rand_ofs();
    e.removed      = rand_len();
    e.inserted     = rand_len();
    e.caret_prior  = rand_ofs();
    e.mark_prior   = rand_ofs();
    e.select_prior = 1'($urandom);
    e.caret_later  = rand_ofs();
    e.mark_later   = rand_ofs();
    e.select_later = 1'($urandom);
    return e;
  endfunction

  function automatic hist_entry_t fill_entry(input logic [OFS_W-1:0] v,
                                             input logic [OFS_W-1:0] rem,
                                             input logic [OFS_W-1:0] ins, input logic s);
    return '{pos: v, removed: rem, inserted: ins, caret_prior: v, mark_prior: ~v,
             select_prior: s, caret_later: ~v, mark_later: v, select_later: ~s};
  endfunction

  // Present one word at a falling edge and hold it until the block takes it
  task automatic send_word(input cmd_t c, input hist_entry_t e);
    if (!calm && $urandom_range(0, 99) < 35) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_cmd   <= c;
    in_word  <= e;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  initial begin
    int          sent;
    int          burst;
    int          kind;
    cmd_t        c;
    hist_entry_t e;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty pops, extreme records, empty record, round trips, clears
    send_word(CMD_UNDO, fill_entry('1, '1, '1, 1'b1));
    send_word(CMD_REDO, fill_entry('1, '1, '1, 1'b1));
    send_word(CMD_RECORD, fill_entry('1, '1, '1, 1'b1));
    send_word(CMD_RECORD, fill_entry('0, '0, 16'd1, 1'b0));
    send_word(CMD_RECORD, fill_entry('1, '0, '0, 1'b1));
    send_word(CMD_RECORD, fill_entry('0, 16'd1, '0, 1'b0));
    send_word(CMD_UNDO, '0);
    send_word(CMD_UNDO, '0);
    send_word(CMD_REDO, '0);
    send_word(CMD_REDO, '0);
    send_word(CMD_REDO, '0);
    send_word(CMD_UNDO, '1);
    send_word(CMD_RECORD, fill_entry(16'hAAAA, 16'h5555, 16'hAAAA, 1'b1));
    send_word(CMD_REDO, '0);
    send_word(CMD_CLEAR, '1);
    send_word(CMD_UNDO, '0);
    send_word(CMD_REDO, '0);
    send_word(CMD_RECORD, fill_entry(16'h5555, 16'hAAAA, 16'h5555, 1'b0));
    send_word(CMD_RECORD, fill_entry(16'h8001, '1, '0, 1'b1));
    send_word(CMD_UNDO, '0);
    send_word(CMD_UNDO, '0);
    send_word(CMD_REDO, '0);
    send_word(CMD_CLEAR, '0);

    // Random bursts: long record runs wrap the undo ring, undo/redo runs walk it back
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 75) : $urandom_range(1, 8);
      kind  = $urandom_range(0, 99);
      for (int k = 0; k < burst && sent < RANDOM_WORDS; k++) begin
        calm <= (sent >= 700 && sent < 950);
        e = random_entry();
        if (kind < 32)      c = CMD_RECORD;
        else if (kind < 57) c = CMD_UNDO;
        else if (kind < 77) c = CMD_REDO;
        else if (kind < 97) c = cmd_t'(2'($urandom_range(0, 3)));
        else                c = CMD_CLEAR;
        send_word(c, e);
        sent++;
      end
    end
    in_valid <= 1'b0;
    calm     <= 1'b0;

    // Drain, then let a few more edges pass for stray words
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
